>>> sv/tpbf_pkg.sv
// shared types, constants and the burst divisor table for the triac firing block
package tpbf_pkg;

    localparam int SPEED_W    = 10;
    localparam int PULSE_W    = 10;
    localparam int HALF_W     = 14;
    localparam int BURST_W    = 7;
    localparam int PROD_W     = 24;
    localparam int RECIP_W    = 25;
    localparam int QUOT_W     = 15;
    localparam int WIDE_W     = PROD_W + RECIP_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 14;
    localparam int OP_KIND_W  = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIRING_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_TICKS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD = 2'd2;

    // register reset values
    localparam logic               RST_FIRING_MODE = 1'b0;
    localparam logic [PULSE_W-1:0] RST_PULSE_TICKS = 10'd100;
    localparam logic [HALF_W-1:0]  RST_HALF_PERIOD = 14'd8991;

    localparam logic MODE_PHASE  = 1'b0;
    localparam logic MODE_BURST  = 1'b1;
    localparam logic ACTION_ZC   = 1'b0;
    localparam logic ACTION_TICK = 1'b1;

    // work codes passed from the classifier to the executer
    localparam logic [OP_KIND_W-1:0] OP_TICK    = 3'd0;
    localparam logic [OP_KIND_W-1:0] OP_STOP    = 3'd1;
    localparam logic [OP_KIND_W-1:0] OP_PH_ZC   = 3'd2;
    localparam logic [OP_KIND_W-1:0] OP_PH_EVAL = 3'd3;
    localparam logic [OP_KIND_W-1:0] OP_BU_ZC   = 3'd4;
    localparam logic [OP_KIND_W-1:0] OP_BU_EVAL = 3'd5;

    localparam logic [SPEED_W-1:0] PHASE_SPEED_LIMIT = 10'd1000;
    localparam logic [SPEED_W-1:0] BURST_SPEED_LIMIT = 10'd100;
    localparam logic [HALF_W-1:0]  HALF_MIN          = 14'd1000;
    localparam logic [HALF_W-1:0]  CLAMP_OFFSET      = 14'd999;
    localparam logic [PROD_W-1:0]  DELAY_SCALE       = 24'd1000;
    // floor(2^34 / 1000), quotient is low by at most one
    localparam logic [RECIP_W-1:0] RECIP_M           = 25'd17179869;
    localparam int                 RECIP_SHIFT       = 34;
    localparam logic [BURST_W-1:0] COUNT_LAST        = 7'd100;

    typedef struct packed {
        logic [OP_KIND_W-1:0] kind;
        logic [SPEED_W-1:0]   speed;
        logic [BURST_W-1:0]   divisor;
    } t_op;

    typedef struct packed {
        logic               firing_mode;
        logic [PULSE_W-1:0] pulse_ticks;
        logic [HALF_W-1:0]  half_ticks;
    } t_cfg;

    // floor(100 / speed) for speed 1 to 99; speed 0 gives 0
    function automatic logic [BURST_W-1:0] burst_div(input logic [SPEED_W-1:0] spd);
        logic [BURST_W-1:0] d;
        if (spd == 10'd0)       d = 7'd0;
        else if (spd == 10'd1)  d = 7'd100;
        else if (spd == 10'd2)  d = 7'd50;
        else if (spd == 10'd3)  d = 7'd33;
        else if (spd == 10'd4)  d = 7'd25;
        else if (spd == 10'd5)  d = 7'd20;
        else if (spd == 10'd6)  d = 7'd16;
        else if (spd == 10'd7)  d = 7'd14;
        else if (spd == 10'd8)  d = 7'd12;
        else if (spd == 10'd9)  d = 7'd11;
        else if (spd == 10'd10) d = 7'd10;
        else if (spd == 10'd11) d = 7'd9;
        else if (spd == 10'd12) d = 7'd8;
        else if (spd <= 10'd14) d = 7'd7;
        else if (spd <= 10'd16) d = 7'd6;
        else if (spd <= 10'd20) d = 7'd5;
        else if (spd <= 10'd25) d = 7'd4;
        else if (spd <= 10'd33) d = 7'd3;
        else if (spd <= 10'd50) d = 7'd2;
        else                    d = 7'd1;
        return d;
    endfunction

endpackage

>>> sv/tpbf_front.sv
// request classifier: owns the speed re-evaluation state and issues work codes
module tpbf_front import tpbf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic               i_action,
    input  logic               i_motor_on,
    input  logic [SPEED_W-1:0] i_speed,
    input  logic               i_firing_mode,
    input  logic               i_cfg_touch,
    input  logic               i_full,
    output logic               o_push,
    output t_op                o_op
);

    logic               r_start_flag, n_start_flag;
    logic [SPEED_W-1:0] r_last_speed, n_last_speed;
    logic               reeval;
    logic               speed_ok;
    logic               is_phase;

    assign o_ready  = !i_full;
    assign o_push   = i_valid && !i_full;
    assign is_phase = (i_firing_mode == MODE_PHASE);
    assign reeval   = r_start_flag || (i_speed != r_last_speed);
    assign speed_ok = (i_speed != '0) &&
                      (is_phase ? (i_speed < PHASE_SPEED_LIMIT) : (i_speed < BURST_SPEED_LIMIT));

    always_comb begin
        o_op.speed   = i_speed;
        o_op.divisor = burst_div(i_speed);
        if (i_action == ACTION_TICK) begin
            o_op.kind = OP_TICK;
        end else if (!i_motor_on) begin
            o_op.kind = OP_STOP;
        end else if (reeval) begin
            if (!speed_ok)     o_op.kind = OP_STOP;
            else if (is_phase) o_op.kind = OP_PH_EVAL;
            else               o_op.kind = OP_BU_EVAL;
        end else begin
            o_op.kind = is_phase ? OP_PH_ZC : OP_BU_ZC;
        end
    end

    always_comb begin
        n_start_flag = r_start_flag;
        n_last_speed = r_last_speed;
        if (i_cfg_touch) begin
            n_start_flag = 1'b1;
        end else if (o_push && (i_action == ACTION_ZC)) begin
            if (!i_motor_on) begin
                n_start_flag = 1'b1;
            end else if (reeval) begin
                // speed is latched even when it fails the range test
                n_last_speed = i_speed;
                n_start_flag = !speed_ok;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_flag <= 1'b1;
            r_last_speed <= '0;
        end else begin
            r_start_flag <= n_start_flag;
            r_last_speed <= n_last_speed;
        end
    end

endmodule

>>> sv/tpbf_queue.sv
// small fifo of work codes between classifier and executer
module tpbf_queue import tpbf_pkg::*; #(
    parameter int DEPTH = 2
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_op  i_op,
    output logic o_full,
    output logic o_valid,
    output t_op  o_op,
    input  logic i_pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_op              r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_op    = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_op;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

>>> sv/tpbf_back.sv
// executer: delay and pulse timers, burst counter, phase delay computation, result register
module tpbf_back import tpbf_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_cfg i_cfg,
    input  logic i_op_valid,
    input  t_op  i_op,
    output logic o_pop,
    output logic o_valid,
    input  logic i_ready,
    output logic o_gate,
    output logic o_stop_request
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RECIP = 2'd1;
    localparam logic [1:0] S_FIX   = 2'd2;

    logic [1:0]         r_state, n_state;
    logic [HALF_W-1:0]  r_firing_delay, n_firing_delay;
    logic [HALF_W-1:0]  r_delay_counter, n_delay_counter;
    logic               r_delay_running, n_delay_running;
    logic [PULSE_W-1:0] r_pulse_counter, n_pulse_counter;
    logic               r_gate_level, n_gate_level;
    logic [BURST_W-1:0] r_half_count, n_half_count;
    logic [BURST_W-1:0] r_burst_div, n_burst_div;
    logic [BURST_W-1:0] r_burst_mod, n_burst_mod;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [QUOT_W-1:0]  r_quot, n_quot;
    logic               r_out_valid, n_out_valid;
    logic               r_out_gate, n_out_gate;
    logic               r_out_stop, n_out_stop;

    logic               slot_free;
    logic [PULSE_W-1:0] eff_pulse;
    logic [HALF_W-1:0]  eff_half;
    logic [HALF_W-1:0]  clamp_lim;
    logic [WIDE_W-1:0]  wide_prod;
    logic [PROD_W-1:0]  rem;
    logic [QUOT_W-1:0]  quot_fix;
    logic [HALF_W-1:0]  delay_val;
    logic [HALF_W-1:0]  dc_dec;
    logic               do_arm;
    logic [HALF_W-1:0]  arm_value;
    logic               out_load;
    logic               out_stop;
    logic [BURST_W-1:0] b_count, b_div, b_mod, b_count_nx, b_mod_nx;

    assign slot_free = !r_out_valid || i_ready;
    assign eff_pulse = (i_cfg.pulse_ticks == '0) ? PULSE_W'(1) : i_cfg.pulse_ticks;
    assign eff_half  = (i_cfg.half_ticks < HALF_MIN) ? HALF_MIN : i_cfg.half_ticks;
    assign clamp_lim = eff_half - CLAMP_OFFSET;
    assign wide_prod = {{RECIP_W{1'b0}}, r_prod} * {{PROD_W{1'b0}}, RECIP_M};
    // reciprocal quotient is at most one short, one compare fixes it
    assign rem       = r_prod - {{(PROD_W-QUOT_W){1'b0}}, r_quot} * DELAY_SCALE;
    assign quot_fix  = (rem >= DELAY_SCALE) ? r_quot + 1'b1 : r_quot;
    assign delay_val = (quot_fix > {1'b0, clamp_lim}) ? clamp_lim : quot_fix[HALF_W-1:0];
    assign dc_dec    = (r_delay_counter != '0) ? r_delay_counter - 1'b1 : '0;

    // burst half-cycle step, mod tracked alongside the wrapping counter
    always_comb begin
        b_count    = (i_op.kind == OP_BU_EVAL) ? '0 : r_half_count;
        b_div      = (i_op.kind == OP_BU_EVAL) ? i_op.divisor : r_burst_div;
        b_mod      = (i_op.kind == OP_BU_EVAL) ? '0 : r_burst_mod;
        b_count_nx = (b_count == COUNT_LAST) ? '0 : b_count + 1'b1;
        if ((b_count_nx == '0) || (b_mod + 1'b1 == b_div)) begin
            b_mod_nx = '0;
        end else begin
            b_mod_nx = b_mod + 1'b1;
        end
    end

    always_comb begin
        n_state         = r_state;
        n_firing_delay  = r_firing_delay;
        n_delay_counter = r_delay_counter;
        n_delay_running = r_delay_running;
        n_pulse_counter = r_pulse_counter;
        n_gate_level    = r_gate_level;
        n_half_count    = r_half_count;
        n_burst_div     = r_burst_div;
        n_burst_mod     = r_burst_mod;
        n_prod          = r_prod;
        n_quot          = r_quot;
        o_pop           = 1'b0;
        do_arm          = 1'b0;
        arm_value       = r_firing_delay;
        out_load        = 1'b0;
        out_stop        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_op_valid) begin
                    if (i_op.kind == OP_PH_EVAL) begin
                        o_pop   = 1'b1;
                        n_prod  = {{(PROD_W-HALF_W){1'b0}}, eff_half} *
                                  {{(PROD_W-SPEED_W){1'b0}}, PHASE_SPEED_LIMIT - i_op.speed};
                        n_state = S_RECIP;
                    end else if (slot_free) begin
                        o_pop    = 1'b1;
                        out_load = 1'b1;
                        case (i_op.kind)
                            OP_TICK: begin
                                if (r_pulse_counter != '0) begin
                                    n_pulse_counter = r_pulse_counter - 1'b1;
                                    if (r_pulse_counter == PULSE_W'(1)) n_gate_level = 1'b0;
                                end
                                if (r_delay_running) begin
                                    n_delay_counter = dc_dec;
                                    if (dc_dec == '0) begin
                                        n_delay_running = 1'b0;
                                        n_gate_level    = 1'b1;
                                        n_pulse_counter = eff_pulse;
                                    end
                                end
                            end
                            OP_STOP: begin
                                n_delay_running = 1'b0;
                                n_delay_counter = '0;
                                n_pulse_counter = '0;
                                n_gate_level    = 1'b0;
                                out_stop        = 1'b1;
                            end
                            OP_PH_ZC: begin
                                do_arm = 1'b1;
                            end
                            OP_BU_ZC, OP_BU_EVAL: begin
                                n_delay_running = 1'b0;
                                n_delay_counter = '0;
                                n_pulse_counter = '0;
                                n_half_count    = b_count_nx;
                                n_burst_div     = b_div;
                                n_burst_mod     = b_mod_nx;
                                n_gate_level    = (b_div == '0) || (b_mod_nx == '0);
                            end
                            default: begin
                                n_gate_level = r_gate_level;
                            end
                        endcase
                    end
                end
            end
            S_RECIP: begin
                n_quot  = wide_prod[RECIP_SHIFT +: QUOT_W];
                n_state = S_FIX;
            end
            S_FIX: begin
                if (slot_free) begin
                    n_firing_delay = delay_val;
                    arm_value      = delay_val;
                    do_arm         = 1'b1;
                    out_load       = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // phase zero cross: drop the gate and restart the delay, or fire at once when the delay is zero
        if (do_arm) begin
            n_gate_level    = 1'b0;
            n_pulse_counter = '0;
            if (arm_value != '0) begin
                n_delay_counter = arm_value;
                n_delay_running = 1'b1;
            end else begin
                n_delay_running = 1'b0;
                n_delay_counter = '0;
                n_gate_level    = 1'b1;
                n_pulse_counter = eff_pulse;
            end
        end
    end

    always_comb begin
        n_out_valid = r_out_valid && !i_ready;
        n_out_gate  = r_out_gate;
        n_out_stop  = r_out_stop;
        if (out_load) begin
            n_out_valid = 1'b1;
            n_out_gate  = n_gate_level;
            n_out_stop  = out_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_firing_delay  <= '0;
            r_delay_counter <= '0;
            r_delay_running <= 1'b0;
            r_pulse_counter <= '0;
            r_gate_level    <= 1'b0;
            r_half_count    <= '0;
            r_burst_div     <= '0;
            r_burst_mod     <= '0;
            r_out_valid     <= 1'b0;
        end else begin
            r_state         <= n_state;
            r_firing_delay  <= n_firing_delay;
            r_delay_counter <= n_delay_counter;
            r_delay_running <= n_delay_running;
            r_pulse_counter <= n_pulse_counter;
            r_gate_level    <= n_gate_level;
            r_half_count    <= n_half_count;
            r_burst_div     <= n_burst_div;
            r_burst_mod     <= n_burst_mod;
            r_out_valid     <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod     <= n_prod;
        r_quot     <= n_quot;
        r_out_gate <= n_out_gate;
        r_out_stop <= n_out_stop;
    end

    assign o_valid        = r_out_valid;
    assign o_gate         = r_out_gate;
    assign o_stop_request = r_out_stop;

endmodule

>>> sv/triac_phase_burst_firing.sv
// top level of the triac gate drive with phase-angle and burst firing
//
//  channel   direction  handshake            payload
//  request   in         i_valid / o_ready    i_action, i_motor_on, i_speed
//  result    out        o_valid / i_ready    o_gate, o_stop_request
//  config    in         i_cfg_we             i_cfg_index, i_cfg_wdata
//
// ticks and plain zero crosses are done in the executer idle state once the
// result register is free; a zero cross that recomputes the phase delay goes
// through three steps (product, reciprocal multiply, correct and clamp).
// the classifier takes a request whenever the work queue has room, so the
// input side keeps moving while a result waits in the output register.
// reset is synchronous, active low, and restores the register defaults.
module triac_phase_burst_firing import tpbf_pkg::*; #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic                  i_action,
    input  logic                  i_motor_on,
    input  logic [SPEED_W-1:0]    i_speed,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic                  o_gate,
    output logic                  o_stop_request,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg r_cfg, n_cfg;
    logic cfg_touch;
    logic q_push, q_full, q_valid, q_pop;
    t_op  front_op, q_op;

    always_comb begin
        n_cfg     = r_cfg;
        cfg_touch = 1'b0;
        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FIRING_MODE: begin
                    n_cfg.firing_mode = i_cfg_wdata[0];
                    cfg_touch         = 1'b1;
                end
                CFG_PULSE_TICKS: begin
                    n_cfg.pulse_ticks = i_cfg_wdata[PULSE_W-1:0];
                    cfg_touch         = 1'b1;
                end
                CFG_HALF_PERIOD: begin
                    n_cfg.half_ticks = i_cfg_wdata[HALF_W-1:0];
                    cfg_touch        = 1'b1;
                end
                default: begin
                    cfg_touch = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.firing_mode <= RST_FIRING_MODE;
            r_cfg.pulse_ticks <= RST_PULSE_TICKS;
            r_cfg.half_ticks  <= RST_HALF_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    tpbf_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_action      (i_action),
        .i_motor_on    (i_motor_on),
        .i_speed       (i_speed),
        .i_firing_mode (r_cfg.firing_mode),
        .i_cfg_touch   (cfg_touch),
        .i_full        (q_full),
        .o_push        (q_push),
        .o_op          (front_op)
    );

    tpbf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_op    (front_op),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_op    (q_op),
        .i_pop   (q_pop)
    );

    tpbf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_op_valid     (q_valid),
        .i_op           (q_op),
        .o_pop          (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gate         (o_gate),
        .o_stop_request (o_stop_request)
    );

endmodule

>>> tb/triac_firing_checker.sv
`timescale 1ns / 100ps
// gate and stop prediction for the triac firing block, compared against every accepted result
module triac_firing_checker import tpbf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_req_valid,
    input  logic                  i_req_ready,
    input  logic                  i_action,
    input  logic                  i_motor_on,
    input  logic [SPEED_W-1:0]    i_speed,
    input  logic                  i_res_valid,
    input  logic                  i_res_ready,
    input  logic                  i_gate,
    input  logic                  i_stop_request,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output int                    o_pending,
    output int                    o_fail_count
);

    localparam int PHASE_LIMIT = 1000;
    localparam int BURST_LIMIT = 100;
    localparam int HALF_FLOOR  = 1000;
    localparam int CLAMP_BACK  = 999;
    localparam int COUNT_WRAP  = 100;

    typedef struct packed {
        logic gate;
        logic stop;
    } t_drive;

    t_drive drive_q[$];

    // register copies
    logic               mode_q;
    logic [PULSE_W-1:0] pulse_cfg;
    logic [HALF_W-1:0]  half_cfg;

    // firing state
    logic               need_eval;
    logic [SPEED_W-1:0] held_speed;
    logic [BURST_W-1:0] half_count;
    logic [BURST_W-1:0] skip_div;
    logic [HALF_W-1:0]  fire_delay;
    logic [HALF_W-1:0]  delay_left;
    logic               delay_active;
    logic [PULSE_W-1:0] pulse_left;
    logic               gate_lvl;

    int     fails;
    int     res_seen;
    t_drive want;
    t_drive got;
    logic   stop_now;

    task automatic report_mismatch(input string msg);
        fails++;
        if (fails <= 50)
            $display("%0t result %0d: %s", $time, res_seen, msg);
    endtask

    function automatic logic [PULSE_W-1:0] pulse_width();
        return (pulse_cfg == '0) ? PULSE_W'(1) : pulse_cfg;
    endfunction

    task automatic stop_firing();
        delay_active = 1'b0;
        delay_left   = '0;
        pulse_left   = '0;
        gate_lvl     = 1'b0;
        need_eval    = 1'b1;
    endtask

    task automatic zero_cross(input logic motor, input logic [SPEED_W-1:0] spd,
                              output logic stop);
        int h;
        int d;
        logic rejected;
        stop = 1'b0;
        rejected = 1'b0;
        if (!motor) begin
            stop_firing();
            stop = 1'b1;
        end else if (mode_q == MODE_PHASE) begin
            gate_lvl   = 1'b0;
            pulse_left = '0;
            if (need_eval || spd != held_speed) begin
                need_eval  = 1'b0;
                held_speed = spd;
                if (spd == 0 || int'(spd) >= PHASE_LIMIT) begin
                    stop_firing();
                    stop = 1'b1;
                    rejected = 1'b1;
                end else begin
                    h = (int'(half_cfg) < HALF_FLOOR) ? HALF_FLOOR : int'(half_cfg);
                    d = (h * (PHASE_LIMIT - int'(spd))) / PHASE_LIMIT;
                    if (d > h - CLAMP_BACK)
                        d = h - CLAMP_BACK;
                    fire_delay = d[HALF_W-1:0];
                end
            end
            if (!rejected) begin
                if (fire_delay != '0) begin
                    delay_left   = fire_delay;
                    delay_active = 1'b1;
                end else begin
                    // zero delay fires straight away
                    delay_active = 1'b0;
                    delay_left   = '0;
                    gate_lvl     = 1'b1;
                    pulse_left   = pulse_width();
                end
            end
        end else begin
            delay_active = 1'b0;
            delay_left   = '0;
            pulse_left   = '0;
            if (need_eval || spd != held_speed) begin
                need_eval  = 1'b0;
                held_speed = spd;
                half_count = '0;
                skip_div   = '0;
                if (spd == 0 || int'(spd) >= BURST_LIMIT) begin
                    stop_firing();
                    stop = 1'b1;
                    rejected = 1'b1;
                end else begin
                    skip_div = BURST_W'(BURST_LIMIT / int'(spd));
                end
            end
            if (!rejected) begin
                half_count = half_count + 1'b1;
                if (int'(half_count) > COUNT_WRAP)
                    half_count = '0;
                if (skip_div == '0)
                    gate_lvl = 1'b1;
                else
                    gate_lvl = ((half_count % skip_div) == '0);
            end
        end
    endtask

    task automatic timer_tick();
        if (pulse_left != '0) begin
            pulse_left = pulse_left - 1'b1;
            if (pulse_left == '0)
                gate_lvl = 1'b0;
        end
        if (delay_active) begin
            if (delay_left != '0)
                delay_left = delay_left - 1'b1;
            if (delay_left == '0) begin
                delay_active = 1'b0;
                gate_lvl     = 1'b1;
                pulse_left   = pulse_width();
            end
        end
    endtask

    initial begin
        fails    = 0;
        res_seen = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            mode_q       = RST_FIRING_MODE;
            pulse_cfg    = RST_PULSE_TICKS;
            half_cfg     = RST_HALF_PERIOD;
            need_eval    = 1'b1;
            held_speed   = '0;
            half_count   = '0;
            skip_div     = '0;
            fire_delay   = '0;
            delay_left   = '0;
            delay_active = 1'b0;
            pulse_left   = '0;
            gate_lvl     = 1'b0;
            drive_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_FIRING_MODE: begin
                        mode_q    = i_cfg_wdata[0];
                        need_eval = 1'b1;
                    end
                    CFG_PULSE_TICKS: begin
                        pulse_cfg = i_cfg_wdata[PULSE_W-1:0];
                        need_eval = 1'b1;
                    end
                    CFG_HALF_PERIOD: begin
                        half_cfg  = i_cfg_wdata[HALF_W-1:0];
                        need_eval = 1'b1;
                    end
                    default: ;
                endcase
            end
            if (i_req_valid && i_req_ready) begin
                stop_now = 1'b0;
                if (i_action == ACTION_ZC)
                    zero_cross(i_motor_on, i_speed, stop_now);
                else
                    timer_tick();
                want.gate = gate_lvl;
                want.stop = stop_now;
                drive_q.push_back(want);
            end
            if (i_res_valid && i_res_ready) begin
                got.gate = i_gate;
                got.stop = i_stop_request;
                if (drive_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result gate=%0b stop=%0b",
                                              got.gate, got.stop));
                end else begin
                    want = drive_q.pop_front();
                    if (got.gate !== want.gate)
                        report_mismatch($sformatf("gate %0b, expected %0b",
                                                  got.gate, want.gate));
                    if (got.stop !== want.stop)
                        report_mismatch($sformatf("stop_request %0b, expected %0b",
                                                  got.stop, want.stop));
                end
                res_seen++;
            end
        end
        o_pending    <= drive_q.size();
        o_fail_count <= fails;
    end

endmodule

>>> tb/tb_triac_phase_burst_firing.sv
`timescale 1ns / 100ps
// testbench top for the triac firing block: clock, reset, request and config stimulus, verdict
module tb_triac_phase_burst_firing;
    import tpbf_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_valid;
    logic                  o_ready;
    logic                  i_action;
    logic                  i_motor_on;
    logic [SPEED_W-1:0]    i_speed;
    logic                  o_valid;
    logic                  i_ready;
    logic                  o_gate;
    logic                  o_stop_request;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    int                    pending;
    int                    fail_count;
    logic                  cur_mode;
    logic [SPEED_W-1:0]    cur_speed;

    triac_phase_burst_firing u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_action       (i_action),
        .i_motor_on     (i_motor_on),
        .i_speed        (i_speed),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_gate         (o_gate),
        .o_stop_request (o_stop_request),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    triac_firing_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_ready    (o_ready),
        .i_action       (i_action),
        .i_motor_on     (i_motor_on),
        .i_speed        (i_speed),
        .i_res_valid    (o_valid),
        .i_res_ready    (i_ready),
        .i_gate         (o_gate),
        .i_stop_request (o_stop_request),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_pending      (pending),
        .o_fail_count   (fail_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("Mismatches found");
        $finish;
    end

    // mostly short gaps, now and then a long one
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, plus a long hold-off every few hundred results
    initial begin : result_sink
        int taken;
        int quiet_left;
        int busy_left;
        int next_long;
        taken      = 0;
        quiet_left = 0;
        busy_left  = 4;
        next_long  = 350;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && i_ready)
                taken++;
            if (taken >= next_long) begin
                quiet_left = 250;
                next_long  = next_long + 400;
            end
            if (quiet_left > 0) begin
                quiet_left--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                if (busy_left > 0)
                    busy_left--;
                if (busy_left == 0) begin
                    quiet_left = idle_len();
                    busy_left  = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 80)
                                                             : $urandom_range(1, 6);
                end
            end
        end
    end

    task automatic send_item(input logic act, input logic mot, input logic [SPEED_W-1:0] spd);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_action   <= act;
        i_motor_on <= mot;
        i_speed    <= spd;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
    endtask

    task automatic set_config(input logic mode, input logic [PULSE_W-1:0] pulse,
                              input logic [HALF_W-1:0] half);
        drain_results();
        cfg_write(CFG_FIRING_MODE, CFG_DATA_W'(mode));
        cfg_write(CFG_PULSE_TICKS, CFG_DATA_W'(pulse));
        cfg_write(CFG_HALF_PERIOD, CFG_DATA_W'(half));
        i_cfg_we <= 1'b0;
        cur_mode = mode;
    endtask

    task automatic run_random(input int count);
        int r;
        logic act;
        logic mot;
        logic [SPEED_W-1:0] spd;
        for (int n = 0; n < count; n++) begin
            mot = ($urandom_range(0, 19) != 0);
            r   = $urandom_range(0, 99);
            if (cur_mode == MODE_PHASE) begin
                act = (r < 10) ? ACTION_ZC : ACTION_TICK;
                r   = $urandom_range(0, 99);
                if (r < 40)      spd = cur_speed;
                else if (r < 70) spd = SPEED_W'($urandom_range(990, 999));
                else if (r < 85) spd = SPEED_W'($urandom_range(900, 999));
                else if (r < 95) spd = SPEED_W'($urandom_range(1, 999));
                else             spd = SPEED_W'($urandom_range(0, 1023));
            end else begin
                act = (r < 75) ? ACTION_ZC : ACTION_TICK;
                r   = $urandom_range(0, 99);
                if (r < 50)      spd = cur_speed;
                else if (r < 92) spd = SPEED_W'($urandom_range(1, 99));
                else if (r < 97) spd = SPEED_W'($urandom_range(100, 1023));
                else             spd = '0;
            end
            if (act == ACTION_TICK) begin
                // ticks ignore motor and speed, so scramble them
                mot = ($urandom_range(0, 1) != 0);
                spd = SPEED_W'($urandom_range(0, 1023));
            end else begin
                cur_speed = spd;
            end
            send_item(act, mot, spd);
        end
    endtask

    initial begin : stimulus
        i_rst_n     <= 1'b0;
        i_valid     <= 1'b0;
        i_action    <= ACTION_ZC;
        i_motor_on  <= 1'b0;
        i_speed     <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_FIRING_MODE;
        i_cfg_wdata <= '0;
        cur_mode  = MODE_PHASE;
        cur_speed = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // phase mode at reset defaults: stops, then a short delay that fires
        send_item(ACTION_ZC, 1'b0, 10'd500);
        send_item(ACTION_ZC, 1'b1, 10'd0);
        send_item(ACTION_ZC, 1'b1, 10'd1023);
        send_item(ACTION_ZC, 1'b1, 10'd1000);
        send_item(ACTION_ZC, 1'b1, 10'd999);
        repeat (10) send_item(ACTION_TICK, ($urandom_range(0, 1) != 0),
                              SPEED_W'($urandom_range(0, 1023)));
        send_item(ACTION_ZC, 1'b1, 10'd999);
        send_item(ACTION_ZC, 1'b1, 10'd1);
        send_item(ACTION_TICK, 1'b0, 10'd0);

        // burst mode edges
        set_config(MODE_BURST, 10'd100, 14'd8991);
        send_item(ACTION_ZC, 1'b1, 10'd1);
        send_item(ACTION_ZC, 1'b1, 10'd99);
        send_item(ACTION_ZC, 1'b1, 10'd99);
        send_item(ACTION_ZC, 1'b1, 10'd100);
        send_item(ACTION_ZC, 1'b1, 10'd50);
        cur_speed = 10'd50;

        set_config(MODE_PHASE, 10'd1, 14'd1000);
        run_random(125);
        set_config(MODE_PHASE, 10'd1023, 14'd16383);
        run_random(125);
        // out-of-range registers: pulse width of zero and half period below the floor
        set_config(MODE_PHASE, 10'd0, 14'd0);
        run_random(125);
        set_config(MODE_BURST, 10'd37, 14'd8991);
        run_random(125);
        set_config(MODE_PHASE, PULSE_W'($urandom_range(2, 20)),
                   HALF_W'($urandom_range(1000, 1100)));
        run_random(125);
        set_config(MODE_BURST, 10'd1023, 14'd999);
        run_random(125);
        set_config(MODE_PHASE, PULSE_W'($urandom_range(1, 1023)),
                   HALF_W'($urandom_range(1000, 16383)));
        run_random(125);
        // unused index must leave the speed latch alone
        drain_results();
        cfg_write(CFG_SPARE, CFG_DATA_W'($urandom_range(0, 16383)));
        i_cfg_we <= 1'b0;
        run_random(60);
        set_config(MODE_PHASE, 10'd5, 14'd1030);
        run_random(125);

        drain_results();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

>>> triac_phase_burst_firing.f
sv/tpbf_pkg.sv
sv/tpbf_front.sv
sv/tpbf_queue.sv
sv/tpbf_back.sv
sv/triac_phase_burst_firing.sv
tb/triac_firing_checker.sv
tb/tb_triac_phase_burst_firing.sv
